>>> rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and codes of the postfix stack evaluator: token operations,
// status codes, Q16.16 limits and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_FEW  = 3'd2;
    localparam logic [2:0] ST_DIV0 = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    localparam int DIV_STEPS = 48;

    typedef struct packed {
        logic load;
        logic mem_read;
        logic exec;
        logic mul_sat;
        logic div_fin;
        logic commit;
    } pse_cmd_t;

    typedef struct packed {
        logic op_ok;
        logic is_mul;
        logic is_div;
        logic b_zero;
        logic div_done;
    } pse_stat_t;

endpackage

>>> rtl/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div
// Unsigned restoring divider, one quotient bit per cycle. Divides a 48-bit
// dividend by a nonzero 32-bit divisor and pulses done with the quotient.
// ----------------------------------------------------------------------------
module pse_div
    import pse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);

    localparam int NW = $clog2(DIV_STEPS + 1);

    logic          run_reg;
    logic          done_reg;
    logic [NW-1:0] cnt_reg;
    logic [47:0]   quo_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   dvs_reg;
    logic [32:0]   shifted;
    logic [32:0]   diff;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[47]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= run_reg && (cnt_reg == NW'(1));
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && (cnt_reg == NW'(1))) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= 32'd0;
            dvs_reg <= divisor;
            cnt_reg <= NW'(DIV_STEPS);
        end else if (run_reg) begin
            rem_reg <= fits ? diff[31:0] : shifted[31:0];
            quo_reg <= {quo_reg[46:0], fits};
            cnt_reg <= cnt_reg - NW'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Controller of the evaluator: sequences token decode, stack read, arithmetic
// and commit, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module pse_ctrl
    import pse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  pse_stat_t stat,
    output pse_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_MUL2   = 3'd3;
    localparam logic [2:0] S_DIVW   = 3'd4;
    localparam logic [2:0] S_DIVFIN = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       commit;

    assign s_ready = (state_reg == S_IDLE);
    assign commit  = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd          = '0;
        cmd.load     = s_valid && s_ready;
        cmd.commit   = commit;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.op_ok) begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_EXEC;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.is_mul) begin
                    state_next = S_MUL2;
                end else if (stat.is_div && !stat.b_zero) begin
                    state_next = S_DIVW;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_MUL2: begin
                cmd.mul_sat = 1'b1;
                state_next  = S_FINISH;
            end
            S_DIVW: begin
                if (stat.div_done) begin
                    state_next = S_DIVFIN;
                end
            end
            S_DIVFIN: begin
                cmd.div_fin = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// Datapath of the evaluator: token register, top-of-stack register, stack
// memory below the top, add/subtract, multiply, divide and saturation, and the
// result word register.
// ----------------------------------------------------------------------------
module pse_datapath
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pse_cmd_t           cmd,
    output pse_stat_t          stat,
    input  logic [2:0]         s_operation,
    input  logic signed [31:0] s_operand_value,
    input  logic               s_end_of_expression,
    output logic signed [31:0] top_value,
    output logic [3:0]         entry_count,
    output logic [2:0]         status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [31:0]        stack_mem [STACK_DEPTH];

    logic [2:0]         op_reg;
    logic signed [31:0] val_reg;
    logic               eoe_reg;
    logic signed [31:0] top_reg;
    logic [CW-1:0]      count_reg;
    logic signed [31:0] rd_reg;
    logic [31:0]        res_reg;
    logic [2:0]         res_st_reg;
    logic signed [63:0] prod_reg;
    logic               neg_reg;
    logic [31:0]        out_top_reg;
    logic [3:0]         out_count_reg;
    logic [2:0]         out_status_reg;

    logic               is_push;
    logic               is_arith;
    logic               push_ok;
    logic               op_ok;
    logic [CW-1:0]      rd_idx;
    logic [CW-1:0]      wr_idx;
    logic [32:0]        sum33;
    logic               sum_ovf;
    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    logic               div_start;
    logic               div_done;
    logic [47:0]        div_q;
    logic [16:0]        mul_hi;
    logic               mul_ovf;
    logic               q_ovf;

    logic [31:0]        new_top;
    logic [CW-1:0]      new_count;
    logic [2:0]         new_status;
    logic [CW+3:0]      cnt_ext;

    assign is_push  = (op_reg == OP_PUSH);
    assign is_arith = (op_reg >= OP_ADD) && (op_reg <= OP_DIV);
    assign push_ok  = is_push && (count_reg < CW'(STACK_DEPTH));
    assign op_ok    = is_arith && (count_reg >= CW'(2));
    assign rd_idx   = count_reg - CW'(2);
    assign wr_idx   = count_reg - CW'(1);

    assign sum33   = (op_reg == OP_SUB) ? ({rd_reg[31], rd_reg} - {top_reg[31], top_reg})
                                        : ({rd_reg[31], rd_reg} + {top_reg[31], top_reg});
    assign sum_ovf = sum33[32] != sum33[31];

    assign a_mag     = rd_reg[31] ? (~rd_reg + 32'd1) : rd_reg;
    assign b_mag     = top_reg[31] ? (~top_reg + 32'd1) : top_reg;
    assign div_start = cmd.exec && (op_reg == OP_DIV) && (top_reg != 32'sd0);

    assign mul_hi  = prod_reg[63:47];
    assign mul_ovf = !((&mul_hi) || !(|mul_hi));
    assign q_ovf   = neg_reg ? (div_q > 48'h0000_8000_0000) : (div_q[47:31] != 17'd0);

    assign stat.op_ok    = op_ok;
    assign stat.is_mul   = (op_reg == OP_MUL);
    assign stat.is_div   = (op_reg == OP_DIV);
    assign stat.b_zero   = (top_reg == 32'sd0);
    assign stat.div_done = div_done;

    pse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({a_mag, 16'd0}),
        .divisor  (b_mag),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        new_top    = top_reg;
        new_count  = count_reg;
        new_status = ST_OK;
        if (push_ok) begin
            new_top   = val_reg;
            new_count = count_reg + CW'(1);
        end else if (is_push) begin
            new_status = ST_FULL;
        end else if (op_ok) begin
            new_top    = res_reg;
            new_count  = count_reg - CW'(1);
            new_status = res_st_reg;
        end else if (is_arith) begin
            new_status = ST_FEW;
        end
    end

    assign cnt_ext = {4'd0, new_count};

    // token capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_operation;
            val_reg <= s_operand_value;
            eoe_reg <= s_end_of_expression;
        end
    end

    // stack memory
    always_ff @(posedge aclk) begin
        if (cmd.commit && push_ok && (count_reg != CW'(0))) begin
            stack_mem[wr_idx[AW-1:0]] <= top_reg;
        end
        if (cmd.mem_read) begin
            rd_reg <= stack_mem[rd_idx[AW-1:0]];
        end
    end

    // arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            prod_reg   <= rd_reg * top_reg;
            neg_reg    <= rd_reg[31] ^ top_reg[31];
            res_st_reg <= ST_OK;
            if (op_reg == OP_DIV) begin
                if (top_reg == 32'sd0) begin
                    res_reg    <= rd_reg[31] ? Q_MIN : Q_MAX;
                    res_st_reg <= ST_DIV0;
                end
            end else if (sum_ovf) begin
                res_reg    <= sum33[32] ? Q_MIN : Q_MAX;
                res_st_reg <= ST_SAT;
            end else begin
                res_reg <= sum33[31:0];
            end
        end else if (cmd.mul_sat) begin
            if (mul_ovf) begin
                res_reg    <= prod_reg[63] ? Q_MIN : Q_MAX;
                res_st_reg <= ST_SAT;
            end else begin
                res_reg    <= prod_reg[47:16];
                res_st_reg <= ST_OK;
            end
        end else if (cmd.div_fin) begin
            if (q_ovf) begin
                res_reg    <= neg_reg ? Q_MIN : Q_MAX;
                res_st_reg <= ST_SAT;
            end else begin
                res_reg    <= neg_reg ? (~div_q[31:0] + 32'd1) : div_q[31:0];
                res_st_reg <= ST_OK;
            end
        end
    end

    // stack top and result word
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            top_reg        <= new_top;
            out_top_reg    <= (new_count != CW'(0)) ? new_top : 32'd0;
            out_count_reg  <= cnt_ext[3:0];
            out_status_reg <= new_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= eoe_reg ? CW'(0) : new_count;
        end
    end

    assign top_value   = out_top_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

endmodule

>>> rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix evaluator over signed Q16.16 numbers, one token per input word and
// one result word per token.
// ----------------------------------------------------------------------------
// Tokens are taken one at a time. A push, a dropped push, an operator with too
// few entries or an unused code goes from decode straight to its result word;
// add, subtract and divide by zero pass through execute, multiply through
// execute and a second state (product register, then saturation), and other
// divides through execute, the bit-serial divider that produces 48 quotient
// bits one per cycle, and a final sign and saturation state. The next token
// can be taken in the cycle the result word appears. The top entry is held in
// a register and the entries below it in a stack memory with one registered
// read port, read once per operator. A finished result word waits in its
// register while the next token is taken; the block stalls only when a new
// result is ready and the previous one has not been taken.
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic signed [31:0] s_operand_value,
    input  logic               s_end_of_expression,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_top_value,
    output logic [3:0]         m_entry_count,
    output logic [2:0]         m_status
);

    pse_cmd_t  cmd;
    pse_stat_t stat;

    pse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_operation         (s_operation),
        .s_operand_value     (s_operand_value),
        .s_end_of_expression (s_end_of_expression),
        .top_value           (m_top_value),
        .entry_count         (m_entry_count),
        .status              (m_status)
    );

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("result committed over an untaken word");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second token taken while one is in flight");

    a_div_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> !s_ready)
        else $error("divider finished while controller idle");

    a_div0_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_DIV0)) |->
            ((m_top_value == Q_MAX) || (m_top_value == Q_MIN)))
        else $error("divide by zero word not saturated");
`endif

endmodule
